// ===== rtl/core/nv21rot_pkg.sv =====
// Package for the NV21 rotation scatter unit: widths, register indexes,
// the stage-one transaction struct and the dimension clamp.
// No dependencies.
`timescale 1ns / 1ps

package nv21rot_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned DIM_W   = 13;  // register width of a dimension
  localparam int unsigned POS_W   = 12;  // column / row counter width
  localparam int unsigned OFF_W   = 25;  // destination offset width
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 13;  // widest register
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_ROTATION_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  // Stage-one transaction: rotated position plus what the address stage needs.
  typedef struct packed {
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic [DIM_W-1:0] stride;   // row pitch in pixels or pairs
    logic [OFF_W-1:0] base;     // start of the plane in the output frame
    logic             chroma;
    logic             phase;    // 0 = V, 1 = U
    logic             last;     // final U byte of the frame
  } loc_t;

  // Clamp to [2, maxv] and drop the low bit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (r < DIM_W'(2)) r = DIM_W'(2);
    if (r > maxv) r = maxv;
    r[0] = 1'b0;
    if (r < DIM_W'(2)) r = DIM_W'(2);
    return r;
  endfunction

endpackage

// ===== rtl/core/nv21_frame_rotation_scatter_unit.sv =====
// Top level of the NV21 rotation scatter unit: configuration registers,
// handshake and the two pipeline stages.
// Depends on nv21rot_pkg, nv21rot_locate, nv21rot_offset.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   in       | sink      | in_valid/in_stall  | pixel_byte
//   out      | source    | out_valid/out_stall| dest_offset, out_byte, frame_end
//   cfg      | sink      | cfg_we             | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; the stages are position/rotation
// and plane-size multiply into stage one, then row-pitch multiply and add into the output register.
// Reset: 640x480, no rotation, counters at the frame start.
// in_stall follows out_stall only when both stages hold data.
`timescale 1ns / 1ps

module nv21_frame_rotation_scatter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nv21rot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nv21rot_pkg::CFG_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nv21rot_pkg::BYTE_W-1:0]    pixel_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nv21rot_pkg::OFF_W-1:0]     dest_offset,
  output logic [nv21rot_pkg::BYTE_W-1:0]    out_byte,
  output logic                              frame_end
);
  import nv21rot_pkg::*;

  logic [DIM_W-1:0] frame_width, frame_height, w, h;
  rot_t             rotation_mode;
  logic             restart, accept;
  logic             s1_valid, s1_ready, s2_ready;
  loc_t             loc, s1_loc;
  logic [BYTE_W-1:0] s1_byte;

  always_comb begin
    w        = eff_dim(frame_width, DIM_W'(MAX_WIDTH));
    h        = eff_dim(frame_height, DIM_W'(MAX_HEIGHT));
    restart  = cfg_we && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
    s2_ready = !out_valid || !out_stall;
    s1_ready = !s1_valid || s2_ready;
    in_stall = !s1_ready;
    accept   = in_valid && s1_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= DIM_W'(640);
      frame_height  <= DIM_W'(480);
      rotation_mode <= ROT_0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_ROTATION_MODE: rotation_mode <= rot_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  nv21rot_locate u_locate (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .advance (accept),
    .w       (w),
    .h       (h),
    .mode    (rotation_mode),
    .loc     (loc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_loc  <= loc;
      s1_byte <= pixel_byte;
    end
  end

  nv21rot_offset u_offset (
    .clk         (clk),
    .load        (s1_valid && s2_ready),
    .loc         (s1_loc),
    .byte_in     (s1_byte),
    .dest_offset (dest_offset),
    .out_byte    (out_byte),
    .frame_end   (frame_end)
  );

`ifndef SYNTHESIS
  a_end_is_u_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> dest_offset[0])
    else $error("frame end marked on a byte that is not a U byte");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction lost before stage one");

  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("stage-one transaction not moved to output");
`endif

endmodule

// ===== rtl/core/nv21rot_locate.sv =====
// Position tracker for the NV21 rotation scatter unit: plane, row, column
// and pair-phase counters, and the rotated coordinates of the current byte.
// Depends on nv21rot_pkg.
`timescale 1ns / 1ps

module nv21rot_locate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,   // dimension register written
  input  logic                          advance,   // input transaction accepted
  input  logic [nv21rot_pkg::DIM_W-1:0] w,         // effective width
  input  logic [nv21rot_pkg::DIM_W-1:0] h,         // effective height
  input  nv21rot_pkg::rot_t             mode,
  output nv21rot_pkg::loc_t             loc
);
  import nv21rot_pkg::*;

  logic [POS_W-1:0] column_count, column_count_next;
  logic [POS_W-1:0] row_count, row_count_next;
  logic             in_chroma_plane, in_chroma_plane_next;
  logic             pair_phase, pair_phase_next;

  logic [DIM_W-1:0] pw, ph, out_w, col_inc, row_inc;
  logic [POS_W-1:0] pw_m1, ph_m1;
  logic             swap, col_wrap, row_wrap;
  logic [2*DIM_W-1:0] area;

  always_comb begin
    swap  = (mode == ROT_90) || (mode == ROT_270);
    out_w = swap ? h : w;
    pw    = in_chroma_plane ? {1'b0, w[DIM_W-1:1]} : w;
    ph    = in_chroma_plane ? {1'b0, h[DIM_W-1:1]} : h;
    pw_m1 = POS_W'(pw - DIM_W'(1));
    ph_m1 = POS_W'(ph - DIM_W'(1));
    area  = w * h;

    case (mode)
      ROT_90: begin
        loc.ox = ph_m1 - row_count;
        loc.oy = column_count;
      end
      ROT_180: begin
        loc.ox = pw_m1 - column_count;
        loc.oy = ph_m1 - row_count;
      end
      ROT_270: begin
        loc.ox = row_count;
        loc.oy = pw_m1 - column_count;
      end
      default: begin
        loc.ox = column_count;
        loc.oy = row_count;
      end
    endcase

    loc.stride = in_chroma_plane ? {1'b0, out_w[DIM_W-1:1]} : out_w;
    loc.base   = in_chroma_plane ? OFF_W'(area) : '0;
    loc.chroma = in_chroma_plane;
    loc.phase  = pair_phase;

    col_inc  = {1'b0, column_count} + DIM_W'(1);
    row_inc  = {1'b0, row_count} + DIM_W'(1);
    col_wrap = (col_inc >= pw);
    row_wrap = (row_inc >= ph);
    // a chroma column only moves after the U byte
    loc.last = in_chroma_plane && pair_phase && col_wrap && row_wrap;

    column_count_next    = column_count;
    row_count_next       = row_count;
    in_chroma_plane_next = in_chroma_plane;
    pair_phase_next      = pair_phase;
    if (in_chroma_plane && !pair_phase) begin
      pair_phase_next = 1'b1;
    end else begin
      pair_phase_next = 1'b0;
      if (col_wrap) begin
        column_count_next = '0;
        if (row_wrap) begin
          row_count_next       = '0;
          in_chroma_plane_next = !in_chroma_plane;
        end else begin
          row_count_next = POS_W'(row_inc);
        end
      end else begin
        column_count_next = POS_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count    <= '0;
      row_count       <= '0;
      in_chroma_plane <= 1'b0;
      pair_phase      <= 1'b0;
    end else if (advance) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      in_chroma_plane <= in_chroma_plane_next;
      pair_phase      <= pair_phase_next;
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < pw)
    else $error("column counter beyond plane width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_count} < ph)
    else $error("row counter beyond plane height");

  a_phase_luma: assert property (@(posedge clk) disable iff (rst)
    !in_chroma_plane |-> !pair_phase)
    else $error("pair phase set in luma plane");
`endif

endmodule

// ===== rtl/core/nv21rot_offset.sv =====
// Address stage of the NV21 rotation scatter unit: turns a rotated position
// into a byte offset and holds the result register. Depends on nv21rot_pkg.
`timescale 1ns / 1ps

module nv21rot_offset (
  input  logic                           clk,
  input  logic                           load,
  input  nv21rot_pkg::loc_t              loc,
  input  logic [nv21rot_pkg::BYTE_W-1:0] byte_in,
  output logic [nv21rot_pkg::OFF_W-1:0]  dest_offset,
  output logic [nv21rot_pkg::BYTE_W-1:0] out_byte,
  output logic                           frame_end
);
  import nv21rot_pkg::*;

  logic [OFF_W-1:0] prod, idx, offset_next;

  always_comb begin
    prod = OFF_W'(loc.oy) * OFF_W'(loc.stride);
    idx  = prod + OFF_W'(loc.ox);
    if (loc.chroma) begin
      offset_next = loc.base + {idx[OFF_W-2:0], loc.phase};
    end else begin
      offset_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_offset <= offset_next;
      out_byte    <= byte_in;
      frame_end   <= loc.last;
    end
  end

endmodule
